>>> hw/rtl/vec3_arithmetic_unit_macros.svh
// Assertion macros used by the vector unit top module.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef VEC3_ARITHMETIC_UNIT_MACROS_SVH
`define VEC3_ARITHMETIC_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VAU_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vec3 unit check failed");
`define VAU_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("vec3 unit reset check failed");
`else
`define VAU_ASSERT(label, prop)
`define VAU_ASSERT_RST(label, prop)
`endif
`endif

>>> hw/rtl/vau_pkg.sv
`timescale 1ns / 1ps
package vau_pkg;

  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_SADD  = 4'd4,
    OP_SSUB  = 4'd5,
    OP_SMUL  = 4'd6,
    OP_SDIV  = 4'd7,
    OP_NEG   = 4'd8,
    OP_DOT   = 4'd9,
    OP_CROSS = 4'd10,
    OP_MAG   = 4'd11,
    OP_SQMAG = 4'd12,
    OP_NORM  = 4'd13,
    OP_LERP  = 4'd14,
    OP_EQ    = 4'd15
  } op_t;

  typedef struct packed {
    op_t  op;
    logic use_div;
  } cls_t;

  // Classified request as it sits in the queue.
  typedef struct packed {
    cls_t             cls;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [31:0]      s;
    logic [2:0][32:0] d;
  } qent_t;

  // Partial result carried through the square root stages.
  typedef struct packed {
    op_t              op;
    logic             use_div;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             sat;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [31:0]      s;
  } res_t;

  // Side data carried through the divider stages.
  typedef struct packed {
    res_t        res;
    logic [31:0] root;
    logic [2:0]  neg;
    logic [2:0]  zero;
  } dside_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [79:0] v);
    sat_t o;
    if (v[79:31] == {49{v[79]}}) begin
      o.sat = 1'b0;
      o.val = v[31:0];
    end else begin
      o.sat = 1'b1;
      o.val = v[79] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return o;
  endfunction

  function automatic logic signed [79:0] sx(input logic [31:0] v);
    return 80'($signed(v));
  endfunction

  // Magnitude of a signed 32-bit value; the most negative value needs bit 32.
  function automatic logic [32:0] abs33(input logic [31:0] v);
    return v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
  endfunction

endpackage

>>> hw/rtl/vec3_arithmetic_unit.sv
`timescale 1ns / 1ps
`include "vec3_arithmetic_unit_macros.svh"
// Three-component vector ALU in signed fixed point with FRAC_BITS fraction
// bits (Q16.16 by default). It takes one request per clock while out_stall
// is low and returns one result per request, in order. A request passes
// through the two-entry input queue, one multiply stage, one sum and clamp
// stage, 32 square root stages, 32 + FRAC_BITS divider stages and the output
// register. Every request passes through all of them, so the rate is one per
// cycle whatever the mix of operations, unless out_stall holds the pipeline.
// While a result waits on out_stall the execution pipeline holds, and the
// queue still takes up to two more requests before in_stall rises.
module vec3_arithmetic_unit import vau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         req_type,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] az,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic signed [31:0] bz,
  input  logic signed [31:0] scal,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] rx,
  output logic signed [31:0] ry,
  output logic signed [31:0] rz,
  output logic signed [31:0] scalar_out,
  output logic               div_zero,
  output logic               saturated
);

  qent_t                    f_ent;
  logic                     q_full;
  logic                     q_valid;
  logic [$bits(qent_t)-1:0] q_dout;
  logic                     pop;

  vau_front u_front (
    .req_type (req_type),
    .ax       (ax),
    .ay       (ay),
    .az       (az),
    .bx       (bx),
    .by       (by),
    .bz       (bz),
    .scal     (scal),
    .ent      (f_ent)
  );

  assign in_stall = q_full;

  vau_queue #(.W($bits(qent_t))) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (in_valid && !q_full),
    .din   (f_ent),
    .full  (q_full),
    .pop   (pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  vau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (qent_t'(q_dout)),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .rx         (rx),
    .ry         (ry),
    .rz         (rz),
    .scalar_out (scalar_out),
    .div_zero   (div_zero),
    .saturated  (saturated)
  );

  // A stalled result freezes the pipeline, so nothing leaves the queue.
  `VAU_ASSERT(a_no_pop_on_stall, out_valid && out_stall |-> !pop)
  `VAU_ASSERT(a_pop_needs_entry, pop |-> q_valid)
  `VAU_ASSERT_RST(a_reset_empty, rst |=> !out_valid)

endmodule

>>> hw/rtl/vau_front.sv
`timescale 1ns / 1ps
module vau_front import vau_pkg::*; (
  input  logic [3:0]         req_type,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] az,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic signed [31:0] bz,
  input  logic signed [31:0] scal,
  output qent_t              ent
);

  always_comb begin
    ent.cls.op = op_t'(req_type);
    ent.cls.use_div = (ent.cls.op == OP_DIV) || (ent.cls.op == OP_SDIV) ||
                      (ent.cls.op == OP_NORM);
    ent.a[0] = ax;
    ent.a[1] = ay;
    ent.a[2] = az;
    ent.b[0] = bx;
    ent.b[1] = by;
    ent.b[2] = bz;
    ent.s    = scal;
    // Exact b - a for interpolation, one bit wider than the operands.
    ent.d[0] = 33'(bx) - 33'(ax);
    ent.d[1] = 33'(by) - 33'(ay);
    ent.d[2] = 33'(bz) - 33'(az);
  end

endmodule

>>> hw/rtl/vau_queue.sv
`timescale 1ns / 1ps
module vau_queue #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] dout
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign dout  = mem[rp];

endmodule

>>> hw/rtl/vau_sqrt.sv
`timescale 1ns / 1ps
module vau_sqrt #(
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   rad,
  input  logic [PW-1:0] in_pl,
  output logic          out_valid,
  output logic [31:0]   root,
  output logic [PW-1:0] out_pl
);

  localparam int N = 32;

  logic          v  [N+1];
  logic [63:0]   rd [N+1];
  logic [33:0]   rm [N+1];
  logic [31:0]   rt [N+1];
  logic [PW-1:0] pl [N+1];

  assign v[0]  = in_valid;
  assign rd[0] = rad;
  assign rm[0] = '0;
  assign rt[0] = '0;
  assign pl[0] = in_pl;

  // One result bit per stage, taking the radicand two bits at a time from the top.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [35:0] remsh;
    logic [35:0] trial;
    logic        ge;

    always_comb begin
      remsh = {rm[k], rd[k][2*(N-1-k)+1 -: 2]};
      trial = {2'b00, rt[k], 2'b01};
      ge    = (remsh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rd[k+1] <= rd[k];
        pl[k+1] <= pl[k];
        rm[k+1] <= ge ? 34'(remsh - trial) : remsh[33:0];
        rt[k+1] <= {rt[k][30:0], ge};
      end
    end
  end

  assign out_valid = v[N];
  assign root      = rt[N];
  assign out_pl    = pl[N];

endmodule

>>> hw/rtl/vau_div.sv
`timescale 1ns / 1ps
module vau_div import vau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int PW = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [2:0][32+FRAC_BITS-1:0] num,
  input  logic [2:0][32:0]          dvs,
  input  logic [PW-1:0]             in_pl,
  output logic                      out_valid,
  output logic [2:0][32+FRAC_BITS-1:0] quo,
  output logic [PW-1:0]             out_pl
);

  localparam int NW = 32 + FRAC_BITS;

  logic                v  [NW+1];
  logic [2:0][NW-1:0]  n  [NW+1];
  logic [2:0][32:0]    rm [NW+1];
  logic [2:0][32:0]    dv [NW+1];
  logic [PW-1:0]       pl [NW+1];

  assign v[0]  = in_valid;
  assign n[0]  = num;
  assign rm[0] = '0;
  assign dv[0] = dvs;
  assign pl[0] = in_pl;

  // Restoring division, one quotient bit per stage in each of the three lanes.
  // The dividend shifts out at the top while quotient bits shift in below.
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [2:0][33:0]   remsh;
    logic [2:0]         ge;
    logic [2:0][32:0]   rnext;
    logic [2:0][NW-1:0] nnext;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        remsh[l] = {rm[k][l], n[k][l][NW-1]};
        ge[l]    = (remsh[l] >= {1'b0, dv[k][l]});
        rnext[l] = ge[l] ? 33'(remsh[l] - {1'b0, dv[k][l]}) : remsh[l][32:0];
        nnext[l] = {n[k][l][NW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n[k+1]  <= nnext;
        rm[k+1] <= rnext;
        dv[k+1] <= dv[k];
        pl[k+1] <= pl[k];
      end
    end
  end

  assign out_valid = v[NW];
  assign quo       = n[NW];
  assign out_pl    = pl[NW];

endmodule

>>> hw/rtl/vau_back.sv
`timescale 1ns / 1ps
module vau_back import vau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  qent_t              q_data,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output logic signed [31:0] rx,
  output logic signed [31:0] ry,
  output logic signed [31:0] rz,
  output logic signed [31:0] scalar_out,
  output logic               div_zero,
  output logic               saturated
);

  localparam int NW = 32 + FRAC_BITS;

  // The whole pipeline moves only when the output register can take a new value.
  logic adv;
  assign adv = !out_valid || !out_stall;
  assign pop = adv && q_valid;

  // Multiply stage.
  logic signed [32:0] opl [6];
  logic signed [32:0] opr [6];
  logic signed [65:0] prod [6];
  logic               m_valid;
  qent_t              m_ent;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      opl[i] = '0;
      opr[i] = '0;
    end
    unique case (q_data.cls.op)
      OP_MUL, OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          opl[i] = 33'($signed(q_data.a[i]));
          opr[i] = 33'($signed(q_data.b[i]));
        end
      end
      OP_SMUL: begin
        for (int i = 0; i < 3; i++) begin
          opl[i] = 33'($signed(q_data.a[i]));
          opr[i] = 33'($signed(q_data.s));
        end
      end
      OP_MAG, OP_SQMAG, OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          opl[i] = 33'($signed(q_data.a[i]));
          opr[i] = 33'($signed(q_data.a[i]));
        end
      end
      OP_CROSS: begin
        opl[0] = 33'($signed(q_data.a[1]));
        opr[0] = 33'($signed(q_data.b[2]));
        opl[1] = 33'($signed(q_data.a[2]));
        opr[1] = 33'($signed(q_data.b[1]));
        opl[2] = 33'($signed(q_data.a[2]));
        opr[2] = 33'($signed(q_data.b[0]));
        opl[3] = 33'($signed(q_data.a[0]));
        opr[3] = 33'($signed(q_data.b[2]));
        opl[4] = 33'($signed(q_data.a[0]));
        opr[4] = 33'($signed(q_data.b[1]));
        opl[5] = 33'($signed(q_data.a[1]));
        opr[5] = 33'($signed(q_data.b[0]));
      end
      OP_LERP: begin
        for (int i = 0; i < 3; i++) begin
          opl[i] = $signed(q_data.d[i]);
          opr[i] = 33'($signed(q_data.s));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_ent <= q_data;
      for (int i = 0; i < 6; i++) prod[i] <= opl[i] * opr[i];
    end
  end

  // Sum, shift and clamp stage.
  logic signed [79:0] pw [6];
  logic signed [79:0] vw [3];
  logic signed [79:0] scw;
  logic signed [79:0] sqw;
  sat_t               tv [3];
  sat_t               ts;
  res_t               rn;
  logic               a_valid;
  res_t               a_res;
  logic [63:0]        a_sq;

  always_comb begin
    for (int i = 0; i < 6; i++) pw[i] = 80'(prod[i]);
    for (int i = 0; i < 3; i++) vw[i] = '0;
    scw = '0;
    sqw = pw[0] + pw[1] + pw[2];
    unique case (m_ent.cls.op)
      OP_ADD:  for (int i = 0; i < 3; i++) vw[i] = sx(m_ent.a[i]) + sx(m_ent.b[i]);
      OP_SUB:  for (int i = 0; i < 3; i++) vw[i] = sx(m_ent.a[i]) - sx(m_ent.b[i]);
      OP_SADD: for (int i = 0; i < 3; i++) vw[i] = sx(m_ent.a[i]) + sx(m_ent.s);
      OP_SSUB: for (int i = 0; i < 3; i++) vw[i] = sx(m_ent.a[i]) - sx(m_ent.s);
      OP_NEG:  for (int i = 0; i < 3; i++) vw[i] = -sx(m_ent.a[i]);
      OP_MUL, OP_SMUL: for (int i = 0; i < 3; i++) vw[i] = pw[i] >>> FRAC_BITS;
      OP_CROSS: begin
        vw[0] = (pw[0] - pw[1]) >>> FRAC_BITS;
        vw[1] = (pw[2] - pw[3]) >>> FRAC_BITS;
        vw[2] = (pw[4] - pw[5]) >>> FRAC_BITS;
      end
      OP_LERP: begin
        for (int i = 0; i < 3; i++) vw[i] = sx(m_ent.a[i]) + (pw[i] >>> FRAC_BITS);
      end
      OP_DOT, OP_SQMAG: scw = sqw >>> FRAC_BITS;
      OP_EQ: scw = {79'd0, (m_ent.a == m_ent.b)};
      default: begin
      end
    endcase
    for (int i = 0; i < 3; i++) tv[i] = sat32(vw[i]);
    ts = sat32(scw);
    rn.op      = m_ent.cls.op;
    rn.use_div = m_ent.cls.use_div;
    for (int i = 0; i < 3; i++) rn.r[i] = tv[i].val;
    rn.sc  = ts.val;
    rn.sat = tv[0].sat | tv[1].sat | tv[2].sat | ts.sat;
    rn.a   = m_ent.a;
    rn.b   = m_ent.b;
    rn.s   = m_ent.s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_res <= rn;
      a_sq  <= sqw[63:0];
    end
  end

  // Square root of the squared length.
  logic                  s_valid;
  logic [31:0]           s_root;
  logic [$bits(res_t)-1:0] s_pl;
  res_t                  sr;

  vau_sqrt #(.PW($bits(res_t))) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (a_valid),
    .rad       (a_sq),
    .in_pl     (a_res),
    .out_valid (s_valid),
    .root      (s_root),
    .out_pl    (s_pl)
  );

  assign sr = res_t'(s_pl);

  // Divider operands: magnitudes, with the quotient sign kept aside.
  logic [2:0][NW-1:0] dnum;
  logic [2:0][32:0]   ddvs;
  logic [32:0]        am;
  dside_t             ds;

  always_comb begin
    am = '0;
    for (int i = 0; i < 3; i++) begin
      am      = abs33(sr.a[i]);
      dnum[i] = {am[31:0], {FRAC_BITS{1'b0}}};
      unique case (sr.op)
        OP_NORM: begin
          ddvs[i]   = {1'b0, s_root};
          ds.neg[i] = sr.a[i][31];
        end
        OP_SDIV: begin
          ddvs[i]   = abs33(sr.s);
          ds.neg[i] = sr.a[i][31] ^ sr.s[31];
        end
        OP_DIV: begin
          ddvs[i]   = abs33(sr.b[i]);
          ds.neg[i] = sr.a[i][31] ^ sr.b[i][31];
        end
        default: begin
          ddvs[i]   = '0;
          ds.neg[i] = 1'b0;
        end
      endcase
      ds.zero[i] = (ddvs[i] == 33'd0);
    end
    ds.res  = sr;
    ds.root = s_root;
  end

  logic                      d_valid;
  logic [2:0][NW-1:0]        quo;
  logic [$bits(dside_t)-1:0] d_pl;
  dside_t                    dd;

  vau_div #(.FRAC_BITS(FRAC_BITS), .PW($bits(dside_t))) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_valid),
    .num       (dnum),
    .dvs       (ddvs),
    .in_pl     (ds),
    .out_valid (d_valid),
    .quo       (quo),
    .out_pl    (d_pl)
  );

  assign dd = dside_t'(d_pl);

  // Final sign, clamp and flags.
  logic [2:0][31:0]   fr;
  logic [31:0]        fsc;
  logic               fsat;
  logic               fdz;
  logic signed [79:0] qw;
  sat_t               tq;

  always_comb begin
    fr   = dd.res.r;
    fsc  = dd.res.sc;
    fsat = dd.res.sat;
    fdz  = 1'b0;
    qw   = '0;
    tq   = '0;
    if (dd.res.use_div) begin
      for (int i = 0; i < 3; i++) begin
        if (dd.zero[i]) begin
          fr[i] = '0;
          fdz   = 1'b1;
        end else begin
          qw    = dd.neg[i] ? -80'(quo[i]) : 80'(quo[i]);
          tq    = sat32(qw);
          fr[i] = tq.val;
          fsat  = fsat | tq.sat;
        end
      end
    end
    if (dd.res.op == OP_MAG) begin
      tq   = sat32(80'(dd.root));
      fsc  = tq.val;
      fsat = fsat | tq.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx         <= fr[0];
      ry         <= fr[1];
      rz         <= fr[2];
      scalar_out <= fsc;
      div_zero   <= fdz;
      saturated  <= fsat;
    end
  end

endmodule
